// ===== hdl/tht_pkg.sv =====
// ----------------------------------------------------------------------------
// tht_pkg
// Shared types, constants and BCD helpers for the twelve-hour timekeeper.
// ----------------------------------------------------------------------------
package tht_pkg;

    localparam int TIME_W    = 16;
    localparam int DIV_W     = 17;   // divisor must hold a magnitude of 32768
    localparam int DIV_STEPS = TIME_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [TIME_W-1:0] HALF_DAY_SEC = 16'd43200;
    localparam logic [TIME_W-1:0] HOUR_SEC     = 16'd3600;
    localparam logic [TIME_W-1:0] MINUTE_SEC   = 16'd60;
    localparam logic [7:0]        BLANK_CODE   = 8'hAA;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_BLANK  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TIME_W-1:0] quotient;
        logic [DIV_W-1:0]  remainder;
    } div_rsp_t;

    // Binary 0..63 to packed BCD, tens high. Tens by reciprocal (x*13 >> 7).
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [3:0] units;
        prod  = {4'b0, v} * 10'd13;
        tens  = prod[9:7];
        units = 4'(v - {tens, 3'b0} - {2'b0, tens, 1'b0});
        return {1'b0, tens, units};
    endfunction

    function automatic logic bcd_ok(input logic [7:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    function automatic logic [6:0] bcd_value(input logic [7:0] b);
        return 7'({b[7:4], 3'b0}) + 7'({b[7:4], 1'b0}) + 7'(b[3:0]);
    endfunction

endpackage

// ===== hdl/tht_divider.sv =====
// ----------------------------------------------------------------------------
// tht_divider
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module tht_divider
    import tht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [TIME_W-1:0] quo_reg;
    logic [DIV_W-1:0] div_reg;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] step_rem;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[TIME_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = trial >= {1'b0, div_reg};
        step_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= step_rem;
            quo_reg <= {quo_reg[TIME_W-2:0], ge};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/twelve_hour_clock_timekeeper_core.sv =====
// ----------------------------------------------------------------------------
// twelve_hour_clock_timekeeper_core
// Twelve-hour seconds counter with BCD display bytes, tick/adjust/load/blank.
// ----------------------------------------------------------------------------
// One input beat at a time: in_ready is low from acceptance until the result
// has been handed to the output register. A zero adjust takes the same path
// as a tick or load, and a blank does not use the divider. The work is done by
// the shared 16-step restoring divider, run once for count/3600 and once for
// the remainder /60, plus, for a non-zero adjust, once for the truncation
// to a multiple of |adjustment|. A result waiting in the output register does
// not stop the next item from being worked on.
module twelve_hour_clock_timekeeper_core
    import tht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic signed [15:0] adjustment,
    input  logic [7:0]  bcd_hours,
    input  logic [7:0]  bcd_minutes,
    input  logic [7:0]  bcd_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] time_seconds,
    output logic [7:0]  hour_display,
    output logic [7:0]  minute_display,
    output logic [7:0]  second_display,
    output logic        accepted
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVA = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIVH = 3'd3;
    localparam logic [2:0] ST_DIVM = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [TIME_W-1:0] count_reg, count_next;
    logic              blanked_reg, blanked_next;
    logic              swap_reg;
    logic              acc_reg, acc_next;
    logic signed [15:0] adj_reg, adj_next;
    logic [3:0]        hours_reg, hours_next;
    logic [7:0]        res_hour_reg, res_hour_next;
    logic [7:0]        res_min_reg, res_min_next;
    logic [7:0]        res_sec_reg, res_sec_next;
    logic              out_valid_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [7:0]        out_hour_reg, out_min_reg, out_sec_reg;
    logic              out_acc_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              take_in;
    logic              out_free;
    logic [DIV_W-1:0]  adj_mag;
    logic [TIME_W-1:0] trunc;
    logic signed [17:0] adj_sum;
    logic              load_ok;
    logic [6:0]        ld_h, ld_m, ld_s;
    logic [TIME_W-1:0] ld_count;
    logic [7:0]        sec_bcd;

    tht_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign take_in  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        adj_mag  = adjustment[15] ? DIV_W'(-{adjustment[15], adjustment})
                                  : DIV_W'(adjustment);
        trunc    = count_reg - div_rsp.remainder[TIME_W-1:0];
        adj_sum  = $signed({2'b0, trunc}) + 18'(adj_reg);
        ld_h     = bcd_value(bcd_hours);
        ld_m     = bcd_value(bcd_minutes);
        ld_s     = bcd_value(bcd_seconds);
        load_ok  = bcd_ok(bcd_hours) && bcd_ok(bcd_minutes) && bcd_ok(bcd_seconds)
                   && (ld_h >= 7'd1) && (ld_h <= 7'd12)
                   && (ld_m < 7'd60) && (ld_s < 7'd60);
        ld_count = 16'(({9'b0, ld_h} - 16'd1) * HOUR_SEC)
                   + 16'({9'b0, ld_m} * MINUTE_SEC) + {9'b0, ld_s};
        sec_bcd  = to_bcd(div_rsp.remainder[5:0]);
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        blanked_next  = blanked_reg;
        acc_next      = acc_reg;
        adj_next      = adj_reg;
        hours_next    = hours_reg;
        res_hour_next = res_hour_reg;
        res_min_next  = res_min_reg;
        res_sec_next  = res_sec_reg;
        div_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    acc_next     = 1'b0;
                    blanked_next = (operation == OP_BLANK);
                    adj_next     = adjustment;
                    state_next   = ST_PREP;
                    unique case (operation)
                        OP_TICK:
                        begin
                            count_next = (count_reg == HALF_DAY_SEC - 16'd1) ? '0
                                         : count_reg + 16'd1;
                        end
                        OP_ADJUST:
                        begin
                            if (adjustment != '0)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = count_reg;
                                div_req.divisor  = adj_mag;
                                state_next       = ST_DIVA;
                            end
                        end
                        OP_LOAD:
                        begin
                            if (load_ok)
                            begin
                                count_next = ld_count;
                                acc_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_hour_next = BLANK_CODE;
                            res_min_next  = BLANK_CODE;
                            res_sec_next  = BLANK_CODE;
                            state_next    = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIVA:
            begin
                if (div_rsp.done)
                begin
                    if (!adj_sum[17] && (adj_sum < $signed({2'b0, HALF_DAY_SEC})))
                    begin
                        count_next = adj_sum[TIME_W-1:0];
                        acc_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = trunc;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = count_reg;
                div_req.divisor  = DIV_W'(HOUR_SEC);
                state_next       = ST_DIVH;
            end
            ST_DIVH:
            begin
                if (div_rsp.done)
                begin
                    hours_next       = div_rsp.quotient[3:0] + 4'd1;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.remainder[TIME_W-1:0];
                    div_req.divisor  = DIV_W'(MINUTE_SEC);
                    state_next       = ST_DIVM;
                end
            end
            ST_DIVM:
            begin
                if (div_rsp.done)
                begin
                    res_hour_next = to_bcd({2'b0, hours_reg});
                    res_min_next  = to_bcd(div_rsp.quotient[5:0]);
                    res_sec_next  = swap_reg ? {sec_bcd[3:0], sec_bcd[7:4]} : sec_bcd;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            blanked_reg   <= 1'b0;
            swap_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            blanked_reg <= blanked_next;
            if (cfg_write_en)
            begin
                swap_reg <= cfg_write_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        adj_reg      <= adj_next;
        hours_reg    <= hours_next;
        res_hour_reg <= res_hour_next;
        res_min_reg  <= res_min_next;
        res_sec_reg  <= res_sec_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_time_reg <= count_reg;
            out_hour_reg <= res_hour_reg;
            out_min_reg  <= res_min_reg;
            out_sec_reg  <= res_sec_reg;
            out_acc_reg  <= acc_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign time_seconds   = out_time_reg;
    assign hour_display   = out_hour_reg;
    assign minute_display = out_min_reg;
    assign second_display = out_sec_reg;
    assign accepted       = out_acc_reg;

`ifndef SYNTHESIS
    // the count never leaves the half-day range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < HALF_DAY_SEC)
        else $error("seconds count out of range");

    // a busy divider is never restarted
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.busy |-> !div_req.start)
        else $error("divider restarted while busy");

    // no new beat is taken straight after one has been accepted
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> !in_ready)
        else $error("input taken while item in flight");

    // a blanked result never reports an accepted change
    a_blank_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hour_reg == BLANK_CODE) |-> !out_acc_reg)
        else $error("blank result flagged as accepted");
`endif

endmodule
